// ----- src/dekf_pkg.sv -----
package dekf_pkg;

	localparam int DW = 32;
	localparam int FB = 20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_EXEC,
		ST_ITER,
		ST_PACK,
		ST_WRBK,
		ST_ACC,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef enum logic [2:0] {
		OS_NONE,
		OS_Q2,
		OS_XB,
		OS_Y,
		OS_W,
		OS_WT,
		OS_TT
	} osel_t;

	typedef struct packed {
		op_t         op;
		logic [4:0]  a;
		logic [4:0]  b;
		logic [4:0]  dst;
		logic        flg;
		osel_t       osel;
	} instr_t;

	typedef struct packed {
		logic          sat;
		logic [DW-1:0] val;
	} packed_t;

	// scratch memory map
	localparam logic [4:0] A_EX = 5'd0, A_EY = 5'd1, A_EZ = 5'd2, A_EE = 5'd3;
	localparam logic [4:0] A_PX = 5'd4, A_PY = 5'd5, A_PZ = 5'd6, A_PE = 5'd7;
	localparam logic [4:0] A_BE = 5'd8;
	localparam logic [4:0] A_ONE = 5'd9, A_MP = 5'd10, A_MP2 = 5'd11;
	localparam logic [4:0] A_K0 = 5'd12, A_K1 = 5'd13, A_K2 = 5'd14, A_K3 = 5'd15;
	localparam logic [4:0] A_K01 = 5'd16;
	localparam logic [4:0] T0 = 5'd17, T1 = 5'd18, T2 = 5'd19, T3 = 5'd20;
	localparam logic [4:0] T4 = 5'd21, T5 = 5'd22, T6 = 5'd23, R_Q2 = 5'd24;
	localparam logic [4:0] R_NU = 5'd25, R_Y = 5'd26, T7 = 5'd27, R_XB = 5'd28;
	localparam logic [4:0] T8 = 5'd29, R_W = 5'd30, R_WT = 5'd31;

	localparam int NCHAIN = 9;
	localparam logic [4:0] LOAD_LAST = 5'd16;
	localparam logic [5:0] PC_MAIN_LAST = 6'd28;
	localparam logic [5:0] PC_T_LAST = 6'd40;

	function automatic logic [DW-1:0] kval(input logic [4:0] idx);
		logic [DW-1:0] v;
		unique case (idx)
			A_ONE:   v = 32'd1048576;
			A_MP:    v = 32'd983850;
			A_MP2:   v = 32'd1967700;
			A_K0:    v = 32'd452000;
			A_K1:    v = 32'd596804;
			A_K2:    v = 32'd227109;
			A_K3:    v = 32'd18373;
			A_K01:   v = 32'd104858;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic instr_t mk(input op_t op, input logic [4:0] dst,
			input logic [4:0] a, input logic [4:0] b, input logic flg, input osel_t os);
		instr_t r;
		r.op = op; r.dst = dst; r.a = a; r.b = b; r.flg = flg; r.osel = os;
		return r;
	endfunction

	function automatic instr_t prog(input logic [5:0] pc);
		instr_t r;
		unique case (pc)
			6'd0:  r = mk(OP_MUL,  T0,   A_EX,  A_EX, 1'b1, OS_NONE);
			6'd1:  r = mk(OP_MUL,  T1,   A_EY,  A_EY, 1'b1, OS_NONE);
			6'd2:  r = mk(OP_MUL,  T2,   A_EZ,  A_EZ, 1'b1, OS_NONE);
			6'd3:  r = mk(OP_ADD,  T0,   T0,    T1,   1'b1, OS_NONE);
			6'd4:  r = mk(OP_ADD,  T0,   T0,    T2,   1'b1, OS_NONE);
			6'd5:  r = mk(OP_SQRT, T3,   T0,    T0,   1'b1, OS_NONE);
			6'd6:  r = mk(OP_DIV,  T4,   A_EZ,  T3,   1'b1, OS_NONE);
			6'd7:  r = mk(OP_MUL,  T5,   A_BE,  A_EE, 1'b1, OS_NONE);
			6'd8:  r = mk(OP_ADD,  T5,   T5,    T5,   1'b1, OS_NONE);
			6'd9:  r = mk(OP_SUB,  T6,   A_ONE, T4,   1'b1, OS_NONE);
			6'd10: r = mk(OP_MUL,  R_Q2, T5,    T6,   1'b1, OS_Q2);
			6'd11: r = mk(OP_SUB,  R_NU, A_BE,  A_EE, 1'b1, OS_NONE);
			6'd12: r = mk(OP_DIV,  R_Y,  R_NU,  A_BE, 1'b1, OS_Y);
			6'd13: r = mk(OP_MUL,  T7,   A_MP2, R_NU, 1'b1, OS_NONE);
			6'd14: r = mk(OP_DIV,  R_XB, R_Q2,  T7,   1'b1, OS_XB);
			6'd15: r = mk(OP_MUL,  T8,   A_MP,  A_MP, 1'b1, OS_NONE);
			6'd16: r = mk(OP_ADD,  T8,   T8,    T7,   1'b1, OS_NONE);
			6'd17: r = mk(OP_SUB,  T8,   T8,    R_Q2, 1'b1, OS_NONE);
			6'd18: r = mk(OP_SQRT, R_W,  T8,    T8,   1'b1, OS_W);
			6'd19: r = mk(OP_DIV,  T0,   A_ONE, R_XB, 1'b1, OS_NONE);
			6'd20: r = mk(OP_MUL,  T1,   T0,    T0,   1'b1, OS_NONE);
			6'd21: r = mk(OP_MUL,  T2,   T1,    T0,   1'b1, OS_NONE);
			6'd22: r = mk(OP_MUL,  T4,   A_K1,  T0,   1'b1, OS_NONE);
			6'd23: r = mk(OP_SUB,  T4,   A_K0,  T4,   1'b1, OS_NONE);
			6'd24: r = mk(OP_MUL,  T5,   A_K2,  T1,   1'b1, OS_NONE);
			6'd25: r = mk(OP_ADD,  T4,   T4,    T5,   1'b1, OS_NONE);
			6'd26: r = mk(OP_MUL,  T5,   A_K3,  T2,   1'b1, OS_NONE);
			6'd27: r = mk(OP_SUB,  T4,   T4,    T5,   1'b1, OS_NONE);
			6'd28: r = mk(OP_DIV,  R_WT, A_K01, T4,   1'b1, OS_WT);
			6'd29: r = mk(OP_ADD,  T0,   A_PX,  A_EX, 1'b0, OS_NONE);
			6'd30: r = mk(OP_ADD,  T1,   A_PY,  A_EY, 1'b0, OS_NONE);
			6'd31: r = mk(OP_SUB,  T2,   A_BE,  A_EZ, 1'b0, OS_NONE);
			6'd32: r = mk(OP_SUB,  T2,   A_PZ,  T2,   1'b0, OS_NONE);
			6'd33: r = mk(OP_SUB,  T3,   A_PE,  R_NU, 1'b0, OS_NONE);
			6'd34: r = mk(OP_MUL,  T3,   T3,    T3,   1'b0, OS_NONE);
			6'd35: r = mk(OP_MUL,  T0,   T0,    T0,   1'b0, OS_NONE);
			6'd36: r = mk(OP_MUL,  T1,   T1,    T1,   1'b0, OS_NONE);
			6'd37: r = mk(OP_MUL,  T2,   T2,    T2,   1'b0, OS_NONE);
			6'd38: r = mk(OP_ADD,  T0,   T0,    T1,   1'b0, OS_NONE);
			6'd39: r = mk(OP_ADD,  T0,   T0,    T2,   1'b0, OS_NONE);
			6'd40: r = mk(OP_SUB,  T0,   T3,    T0,   1'b0, OS_TT);
			default: r = mk(OP_ADD, T0,  T0,    T0,   1'b0, OS_NONE);
		endcase
		return r;
	endfunction

	// saturate a magnitude into a signed word
	function automatic packed_t pack(input logic neg, input logic [51:0] m);
		packed_t r;
		logic [51:0] lim;
		logic [DW-1:0] v;
		lim = neg ? 52'h0_0000_8000_0000 : 52'h0_0000_7FFF_FFFF;
		r.sat = m > lim;
		v = r.sat ? lim[DW-1:0] : m[DW-1:0];
		r.val = neg ? (~v + 32'd1) : v;
		return r;
	endfunction

endpackage

// ----- src/dis_event_kinematics_filter.sv -----
// Electron-method DIS kinematics and accept/reject filter.
//
// Input channel (in_valid / in_stall): one particle per beat, fields as ports.
// The first final-state electron and proton of the event are kept. Beats that
// do not close the event are taken one per cycle while the block is idle.
// The beat with last_in_event set starts the event computation; in_stall is
// high until its result has been handed to the output register.
//
// Output channel (out_valid / out_stall): one result beat per event, held in
// an output register, so the next event's particles flow in while it waits.
//
// Event end: the scratch memory is loaded, then a microprogram runs on
// one shared add/multiply/divide/root unit. Add and subtract read,
// execute and write back; multiply packs first; divide and root, given
// valid operands, iterate (one quotient or root bit a cycle), then pack.
// An invalid event skips the program.
//
// Reset clears the event flags, sequencer and output valid; weight_max
// returns to 1.0. The scratch memory needs no clearing.
// A stalled receiver holds the result; a second result waits in the
// sequencer's final state, with in_stall high.
module dis_event_kinematics_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [30:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          status,
	input  logic signed [31:0]  particle_id,
	input  logic signed [31:0]  mom_x,
	input  logic signed [31:0]  mom_y,
	input  logic signed [31:0]  mom_z,
	input  logic signed [31:0]  energy,
	input  logic signed [31:0]  beam_energy,
	input  logic                bad_particle,
	input  logic [19:0]         uniform_draw,
	input  logic                last_in_event,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  q_squared,
	output logic signed [31:0]  bjorken_x,
	output logic signed [31:0]  inelasticity,
	output logic signed [31:0]  hadron_mass,
	output logic signed [31:0]  momentum_transfer,
	output logic                transfer_valid,
	output logic signed [31:0]  weight,
	output logic                event_valid,
	output logic                accepted
);
	import dekf_pkg::*;

	state_t state_q, state_d;

	// event bookkeeping
	logic        e_seen_q, p_seen_q, spoiled_q;
	logic        evok_q, ev_p_q, nf_q;
	logic [19:0] draw_q;
	logic [30:0] wmax_q;

	// four-vectors and beam energy; shifted out into memory at event end
	logic [31:0] chain_q [NCHAIN];

	// sequencer
	logic [4:0]  cnt_q;
	logic [5:0]  pc_q;
	logic [5:0]  it_q;
	instr_t      ins;

	// scratch memory, two registered read ports
	logic [31:0] mem_q [32];
	logic [31:0] rda_q, rdb_q;

	// shared unit
	logic [63:0] prod_q;
	logic [51:0] num_q, wide_q;
	logic [33:0] rem_q;
	logic [31:0] den_q, res_q;
	logic        neg_q, rflag_q;

	// kinematics results
	logic [31:0] q2_q, xb_q, y_q, w_q, wt_q, tt_q;
	logic [50:0] accp_q;

	// output register
	logic        ov_q;
	logic [31:0] o_q2_q, o_xb_q, o_y_q, o_w_q, o_tt_q, o_wt_q;
	logic        o_tv_q, o_ev_q, o_acc_q;

	// control strobes
	logic in_acc, out_acc, out_load;
	logic fin_item, e_cap, p_cap, ok_now;

	logic [31:0] ma, mb;
	logic [32:0] sum;
	logic [31:0] addres;
	logic        addsat;
	logic [33:0] drem2, srem2, strial;
	logic        dge, sge;
	packed_t     pk;
	logic [30:0] wm;
	logic        vfin, accv;

	function automatic logic uniform_draw_zero(input logic [19:0] d);
		return d == '0;
	endfunction

	assign ins      = prog(pc_q);
	assign in_acc   = in_valid & ~in_stall;
	assign out_acc  = ov_q & ~out_stall;
	assign fin_item = status == 8'd1;
	assign e_cap    = fin_item & (particle_id == 32'sd11) & ~e_seen_q;
	assign p_cap    = fin_item & (particle_id == 32'sd2212) & ~p_seen_q;
	assign ok_now   = (e_seen_q | e_cap) & ~(spoiled_q | bad_particle);

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && last_in_event) state_d = ok_now ? ST_LOAD : ST_FIN;
			end
			ST_LOAD: begin
				if (cnt_q == LOAD_LAST) state_d = ST_READ;
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: begin
				unique case (ins.op)
					OP_ADD, OP_SUB: state_d = ST_WRBK;
					OP_MUL:         state_d = ST_PACK;
					OP_DIV:         state_d = (rdb_q == '0) ? ST_WRBK : ST_ITER;
					OP_SQRT:        state_d = rda_q[31] ? ST_WRBK : ST_ITER;
					default:        state_d = ST_WRBK;
				endcase
			end
			ST_ITER: begin
				if (it_q == '0) state_d = ST_PACK;
			end
			ST_PACK: state_d = ST_WRBK;
			ST_WRBK: begin
				priority if (pc_q == PC_MAIN_LAST && !ev_p_q) state_d = ST_ACC;
				else if (pc_q == PC_T_LAST) state_d = ST_ACC;
				else state_d = ST_READ;
			end
			ST_ACC: state_d = ST_FIN;
			ST_FIN: begin
				if (!ov_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---- state outputs ----
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_FIN:  out_load = ~ov_q | ~out_stall;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// ---- shared unit, combinational part ----
	always_comb begin
		ma = rda_q[31] ? (~rda_q + 32'd1) : rda_q;
		mb = rdb_q[31] ? (~rdb_q + 32'd1) : rdb_q;
		if (ins.op == OP_SUB) sum = {rda_q[31], rda_q} - {rdb_q[31], rdb_q};
		else sum = {rda_q[31], rda_q} + {rdb_q[31], rdb_q};
		addsat = sum[32] ^ sum[31];
		addres = addsat ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];
		drem2  = {rem_q[32:0], num_q[51]};
		dge    = drem2 >= {2'b00, den_q};
		srem2  = {rem_q[31:0], num_q[51:50]};
		strial = {6'd0, wide_q[25:0], 2'b01};
		sge    = srem2 >= strial;
		pk     = pack(neg_q, (ins.op == OP_MUL) ? {8'd0, prod_q[63:20]} : wide_q);
		wm     = (wmax_q == '0) ? 31'd1 : wmax_q;
		vfin   = evok_q & ~nf_q;
		priority if (wt_q[31] || wt_q == '0) accv = uniform_draw_zero(draw_q);
		else if (wt_q[30:0] >= wm) accv = 1'b1;
		else accv = accp_q <= {wt_q[30:0], 20'd0};
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			e_seen_q  <= 1'b0;
			p_seen_q  <= 1'b0;
			spoiled_q <= 1'b0;
			evok_q    <= 1'b0;
			ev_p_q    <= 1'b0;
			nf_q      <= 1'b0;
			cnt_q     <= '0;
			pc_q      <= '0;
			ov_q      <= 1'b0;
			wmax_q    <= 31'd1048576;
		end else begin
			state_q <= state_d;
			if (cfg_we) wmax_q <= cfg_data;
			if (in_acc) begin
				if (last_in_event) begin
					e_seen_q  <= 1'b0;
					p_seen_q  <= 1'b0;
					spoiled_q <= 1'b0;
					evok_q    <= ok_now;
					ev_p_q    <= p_seen_q | p_cap;
					nf_q      <= 1'b0;
					cnt_q     <= '0;
					pc_q      <= '0;
				end else begin
					if (e_cap) e_seen_q <= 1'b1;
					if (p_cap) p_seen_q <= 1'b1;
					if (bad_particle) spoiled_q <= 1'b1;
				end
			end
			if (state_q == ST_LOAD) cnt_q <= cnt_q + 5'd1;
			if (state_q == ST_WRBK) begin
				pc_q <= pc_q + 6'd1;
				if (ins.flg && rflag_q) nf_q <= 1'b1;
			end
			if (out_load) ov_q <= 1'b1;
			else if (out_acc) ov_q <= 1'b0;
		end
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (e_cap) begin
				chain_q[0] <= mom_x;
				chain_q[1] <= mom_y;
				chain_q[2] <= mom_z;
				chain_q[3] <= energy;
			end
			if (p_cap) begin
				chain_q[4] <= mom_x;
				chain_q[5] <= mom_y;
				chain_q[6] <= mom_z;
				chain_q[7] <= energy;
			end
			if (last_in_event) begin
				chain_q[8] <= beam_energy;
				draw_q     <= uniform_draw;
			end
		end

		unique case (state_q)
			ST_LOAD: begin
				if (cnt_q < 5'(NCHAIN)) begin
					mem_q[cnt_q] <= chain_q[0];
					for (int i = 0; i < NCHAIN - 1; i++) chain_q[i] <= chain_q[i+1];
				end else begin
					mem_q[cnt_q] <= kval(cnt_q);
				end
			end
			ST_READ: begin
				rda_q <= mem_q[ins.a];
				rdb_q <= mem_q[ins.b];
			end
			ST_EXEC: begin
				// root reads one operand twice, so the sign term is zero there
				neg_q   <= rda_q[31] ^ rdb_q[31];
				rem_q   <= '0;
				wide_q  <= '0;
				unique case (ins.op)
					OP_ADD, OP_SUB: begin
						res_q   <= addres;
						rflag_q <= addsat;
					end
					OP_MUL: begin
						prod_q  <= ma * mb;
						rflag_q <= 1'b0;
					end
					OP_DIV: begin
						res_q   <= '0;
						rflag_q <= rdb_q == '0;
						num_q   <= {ma, 20'd0};
						den_q   <= mb;
						it_q    <= 6'd51;
					end
					OP_SQRT: begin
						res_q   <= '0;
						rflag_q <= rda_q[31];
						num_q   <= {1'b0, rda_q[30:0], 20'd0};
						it_q    <= 6'd25;
					end
					default: begin
						res_q   <= '0;
						rflag_q <= 1'b0;
					end
				endcase
			end
			ST_ITER: begin
				it_q <= it_q - 6'd1;
				if (ins.op == OP_SQRT) begin
					rem_q  <= sge ? (srem2 - strial) : srem2;
					wide_q <= {wide_q[50:0], sge};
					num_q  <= {num_q[49:0], 2'b00};
				end else begin
					rem_q  <= dge ? (drem2 - {2'b00, den_q}) : drem2;
					wide_q <= {wide_q[50:0], dge};
					num_q  <= {num_q[50:0], 1'b0};
				end
			end
			ST_PACK: begin
				res_q   <= pk.val;
				rflag_q <= pk.sat;
			end
			ST_WRBK: begin
				mem_q[ins.dst] <= res_q;
				unique case (ins.osel)
					OS_Q2:   q2_q <= res_q;
					OS_XB:   xb_q <= res_q;
					OS_Y:    y_q  <= res_q;
					OS_W:    w_q  <= res_q;
					OS_WT:   wt_q <= res_q;
					OS_TT:   tt_q <= res_q;
					default: begin
					end
				endcase
			end
			ST_ACC: accp_q <= 51'(draw_q * wm);
			default: begin
			end
		endcase

		if (out_load) begin
			o_q2_q  <= vfin ? q2_q : '0;
			o_xb_q  <= vfin ? xb_q : '0;
			o_y_q   <= vfin ? y_q  : '0;
			o_w_q   <= vfin ? w_q  : '0;
			o_wt_q  <= vfin ? wt_q : '0;
			o_tt_q  <= (vfin && ev_p_q) ? tt_q : '0;
			o_tv_q  <= vfin & ev_p_q;
			o_ev_q  <= vfin;
			o_acc_q <= vfin & accv;
		end
	end

	assign out_valid         = ov_q;
	assign q_squared         = o_q2_q;
	assign bjorken_x         = o_xb_q;
	assign inelasticity      = o_y_q;
	assign hadron_mass       = o_w_q;
	assign momentum_transfer = o_tt_q;
	assign transfer_valid    = o_tv_q;
	assign weight            = o_wt_q;
	assign event_valid       = o_ev_q;
	assign accepted          = o_acc_q;

`ifndef SYNTHESIS
	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result appeared outside final state");
	a_acc_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> event_valid)
		else $error("accepted without valid event");
	a_tv_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_valid |-> event_valid)
		else $error("transfer valid on invalid event");
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_valid |-> q_squared == 0 && weight == 0)
		else $error("invalid event with nonzero fields");
	// pc rests one past the last step until the next event starts
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_T_LAST + 6'd1)
		else $error("program counter out of range");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam int FRAC = dekf_pkg::FB;
	localparam longint DMAX = 64'sd2147483647;
	localparam longint DMIN = -64'sd2147483648;
	localparam longint unsigned DEC = 64'd10000000000;
	localparam int STALL_LIMIT = 5000;   // cycles with no beat moving on either side
	localparam int DRAIN_CYCLES = 600;   // longer than one event computation

	// one particle beat plus a directed-table column for a typed-in all-zero result
	typedef struct {
		logic [7:0]         status;
		logic signed [31:0] pid;
		logic signed [31:0] px, py, pz, en, be;
		logic               bad;
		logic [19:0]        draw;
		logic               last;
		bit                 zero_exp;
	} particle_t;

	typedef struct {
		logic signed [31:0] q2, xb, y, w, t;
		logic               tv;
		logic signed [31:0] wt;
		logic               ev, acc;
	} kin_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [30:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] status = '0;
	logic signed [31:0] particle_id = '0, mom_x = '0, mom_y = '0, mom_z = '0;
	logic signed [31:0] energy = '0, beam_energy = '0;
	logic bad_particle = 1'b0;
	logic [19:0] uniform_draw = '0;
	logic last_in_event = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] q_squared, bjorken_x, inelasticity, hadron_mass, momentum_transfer;
	logic transfer_valid, event_valid, accepted;
	logic signed [31:0] weight;

	dis_event_kinematics_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.status(status), .particle_id(particle_id),
		.mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z), .energy(energy),
		.beam_energy(beam_energy), .bad_particle(bad_particle),
		.uniform_draw(uniform_draw), .last_in_event(last_in_event),
		.out_valid(out_valid), .out_stall(out_stall),
		.q_squared(q_squared), .bjorken_x(bjorken_x), .inelasticity(inelasticity),
		.hadron_mass(hadron_mass), .momentum_transfer(momentum_transfer),
		.transfer_valid(transfer_valid), .weight(weight),
		.event_valid(event_valid), .accepted(accepted)
	);

	always #2 clk = ~clk;

	// ---------------- kinematics predictor ----------------
	// event state mirrored from the block
	bit e_seen, p_seen, spoiled;
	longint e_vec[4], p_vec[4];
	logic [30:0] wmax_mirror = 31'd1048576;
	bit ovf;               // saturation seen in the current chain

	kin_t events_pending[$];
	particle_t dir_tab[$];
	int errors = 0;
	bit quiet = 1'b0;      // no-idle stretch on both sides

	function automatic bit gap();
		return !quiet && ($urandom_range(99) < 20);
	endfunction

	function automatic logic [63:0] magn(longint a);
		return a < 0 ? -a : a;
	endfunction

	// saturate a magnitude into the signed word, flagging any clip
	function automatic longint sat_word(bit neg, logic [127:0] m);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (m > lim) begin
			ovf = 1'b1;
			m = lim;
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint q_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > DMAX) begin ovf = 1'b1; return DMAX; end
		if (s < DMIN) begin ovf = 1'b1; return DMIN; end
		return s;
	endfunction

	function automatic longint q_sub(longint a, longint b);
		return q_add(a, -b);
	endfunction

	function automatic longint q_mul(longint a, longint b);
		logic [127:0] p;
		p = {64'b0, magn(a)} * {64'b0, magn(b)};
		return sat_word((a < 0) != (b < 0), p >> FRAC);
	endfunction

	function automatic longint q_div(longint a, longint b);
		logic [127:0] n;
		if (b == 0) begin
			ovf = 1'b1;
			return 0;
		end
		n = {64'b0, magn(a)} << FRAC;
		return sat_word((a < 0) != (b < 0), n / {64'b0, magn(b)});
	endfunction

	function automatic longint q_sqrt(longint a);
		logic [127:0] n;
		logic [63:0] root, c;
		if (a < 0) begin
			ovf = 1'b1;
			return 0;
		end
		n = {64'b0, a} << FRAC;
		root = '0;
		for (int k = 63; k >= 0; k--) begin
			c = root | (64'd1 << k);
			if ({64'b0, c} * {64'b0, c} <= n) root = c;
		end
		return sat_word(1'b0, {64'b0, root});
	endfunction

	// decimal constant in units of 1e-10, rounded to nearest
	function automatic longint q_const(longint unsigned num);
		return longint'(((num << FRAC) + DEC / 2) / DEC);
	endfunction

	// returns 1 when the beat closes an event; r then holds the result
	function automatic bit kin_predict(particle_t b, output kin_t r);
		longint ex, ey, ez, ee, be, one, mp, mp2, pe, cost, q2, nu, yv, xb, w2, wv;
		longint inv, inv2, inv3, poly, wt, dx, dy, dz, de, tt;
		longint unsigned wm;
		bit nf, acc;
		r = '{default: 0};
		if (b.bad) spoiled = 1'b1;
		if (b.status == 8'd1 && b.pid == 32'sd11 && !e_seen) begin
			e_vec = '{b.px, b.py, b.pz, b.en};
			e_seen = 1'b1;
		end
		if (b.status == 8'd1 && b.pid == 32'sd2212 && !p_seen) begin
			p_vec = '{b.px, b.py, b.pz, b.en};
			p_seen = 1'b1;
		end
		if (!b.last) return 1'b0;
		if (e_seen && !spoiled) begin
			ex = e_vec[0]; ey = e_vec[1]; ez = e_vec[2]; ee = e_vec[3];
			be = b.be;
			ovf = 1'b0;
			one = q_const(DEC);
			mp = q_const(64'd9382720813);
			mp2 = q_add(mp, mp);
			pe = q_sqrt(q_add(q_add(q_mul(ex, ex), q_mul(ey, ey)), q_mul(ez, ez)));
			cost = q_div(ez, pe);
			q2 = q_mul(q_add(q_mul(be, ee), q_mul(be, ee)), q_sub(one, cost));
			nu = q_sub(be, ee);
			yv = q_div(nu, be);
			xb = q_div(q2, q_mul(mp2, nu));
			w2 = q_sub(q_add(q_mul(mp, mp), q_mul(mp2, nu)), q2);
			wv = q_sqrt(w2);
			inv = q_div(one, xb);
			inv2 = q_mul(inv, inv);
			inv3 = q_mul(inv2, inv);
			poly = q_sub(q_add(q_sub(q_const(64'd4310610000), q_mul(q_const(64'd5691570000), inv)),
				q_mul(q_const(64'd2165880000), inv2)), q_mul(q_const(64'd175220000), inv3));
			wt = q_div(q_const(64'd1000000000), poly);
			nf = ovf;   // t saturation below never spoils the event
			if (!nf) begin
				r.q2 = q2[31:0]; r.xb = xb[31:0]; r.y = yv[31:0];
				r.w = wv[31:0]; r.wt = wt[31:0];
				if (p_seen) begin
					dx = q_add(p_vec[0], ex);
					dy = q_add(p_vec[1], ey);
					dz = q_sub(p_vec[2], q_sub(be, ez));
					de = q_sub(p_vec[3], nu);
					tt = q_sub(q_mul(de, de),
						q_add(q_add(q_mul(dx, dx), q_mul(dy, dy)), q_mul(dz, dz)));
					r.t = tt[31:0];
					r.tv = 1'b1;
				end
				wm = (wmax_mirror == 0) ? 64'd1 : 64'(wmax_mirror);
				if (wt <= 0) acc = (b.draw == 0);
				else if (longint'(wt) >= longint'(wm)) acc = 1'b1;
				else acc = (64'(b.draw) * wm) <= (64'(wt) << 20);
				r.ev = 1'b1;
				r.acc = acc;
			end
		end
		e_seen = 1'b0;
		p_seen = 1'b0;
		spoiled = 1'b0;
		return 1'b1;
	endfunction

	// ---------------- input side ----------------
	task automatic drive_beat(particle_t b);
		kin_t r;
		while (gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		status <= b.status; particle_id <= b.pid;
		mom_x <= b.px; mom_y <= b.py; mom_z <= b.pz; energy <= b.en;
		beam_energy <= b.be; bad_particle <= b.bad;
		uniform_draw <= b.draw; last_in_event <= b.last;
		do @(posedge clk); while (in_stall);
		if (kin_predict(b, r)) begin
			if (b.zero_exp) r = '{default: 0};
			events_pending = {events_pending, r};
		end
	endtask

	// write weight_max once the block has gone idle
	task automatic write_wmax(logic [30:0] v);
		in_valid <= 1'b0;
		while (events_pending.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		wmax_mirror = v;
	endtask

	function automatic particle_t beat(logic [7:0] st, int pid, int px, int py, int pz,
			int en, int be, bit bad, int draw, bit last, bit zero_exp = 0);
		particle_t b;
		b.status = st; b.pid = pid; b.px = px; b.py = py; b.pz = pz; b.en = en;
		b.be = be; b.bad = bad; b.draw = 20'(draw); b.last = last; b.zero_exp = zero_exp;
		return b;
	endfunction

	task automatic add_row(particle_t b);
		dir_tab = {dir_tab, b};
	endtask

	function automatic int sgn_rand(int mag);
		return int'($urandom_range(2 * mag)) - mag;
	endfunction

	// one event: mostly physical electrons and protons, some pure noise
	task automatic random_event(ref int sent);
		particle_t ev[$];
		particle_t b;
		int n, epos, be, ee;
		n = $urandom_range(1, 6);
		epos = $urandom_range(0, n - 1);
		be = $urandom_range(2 << 20, 20 << 20);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15) begin
				// noise: every field anywhere in its range
				b = beat(8'($urandom), $urandom_range(3) == 0 ? 11 : ($urandom_range(2) == 0 ?
					2212 : int'($urandom)), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom_range(9) == 0, $urandom, 1'b0);
			end else if (i == epos || $urandom_range(9) == 0) begin
				ee = $urandom_range(1 << 18, be);
				b = beat(($urandom_range(9) == 0) ? 8'd2 : 8'd1, 11, sgn_rand(ee / 3),
					sgn_rand(ee / 3), -int'($urandom_range(ee)), ee, $urandom,
					$urandom_range(49) == 0, $urandom, 1'b0);
			end else if ($urandom_range(1) == 0) begin
				b = beat(8'd1, 2212, sgn_rand(1 << 20), sgn_rand(1 << 20),
					sgn_rand(4 << 20), $urandom_range(983850, 6 << 20), $urandom,
					1'b0, $urandom, 1'b0);
			end else begin
				b = beat(8'($urandom_range(3)), int'($urandom_range(400)) - 200,
					$urandom, $urandom, $urandom, $urandom, $urandom, 1'b0, $urandom, 1'b0);
			end
			ev = {ev, b};
		end
		ev[n - 1].last = 1'b1;
		if ($urandom_range(9) != 0) ev[n - 1].be = be;
		if ($urandom_range(3) == 0) ev[n - 1].draw = 20'($urandom_range(3));
		foreach (ev[i]) drive_beat(ev[i]);
		sent += n;
	endtask

	task automatic random_phase(int count);
		int sent;
		sent = 0;
		while (sent < count) random_event(sent);
	endtask

	// ---------------- output side ----------------
	task automatic cmp(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		kin_t e;
		if (out_valid && !out_stall) begin
			if (events_pending.size() == 0) begin
				$error("result beat with no event pending");
				errors++;
			end else begin
				e = events_pending.pop_front();
				cmp("q_squared", e.q2, q_squared);
				cmp("bjorken_x", e.xb, bjorken_x);
				cmp("inelasticity", e.y, inelasticity);
				cmp("hadron_mass", e.w, hadron_mass);
				cmp("momentum_transfer", e.t, momentum_transfer);
				cmp("transfer_valid", e.tv, transfer_valid);
				cmp("weight", e.wt, weight);
				cmp("event_valid", e.ev, event_valid);
				cmp("accepted", e.acc, accepted);
			end
		end
		out_stall <= gap();
	end

	// watchdog: nothing moved for too long
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	localparam int G = 1 << 20;   // 1 GeV

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: invalid cases read off directly, the rest predicted
		// proton only, no electron
		add_row(beat(1, 2212, 0, 0, G, 2 * G, 10 * G, 0, 0, 1, 1));
		// non-final electron is never kept
		add_row(beat(2, 11, G, 0, -3 * G, 4 * G, 10 * G, 0, 0, 1, 1));
		// electron with zero momentum
		add_row(beat(1, 11, 0, 0, 0, 3 * G, 10 * G, 0, 0, 1, 1));
		// unreadable particle spoils the event
		add_row(beat(1, 11, G, G / 2, -4 * G, 5 * G, 0, 0, 0, 0));
		add_row(beat(1, 22, 0, 0, 0, 0, 0, 1, 0, 1, 1));
		// zero beam energy
		add_row(beat(1, 11, G, G / 2, -4 * G, 5 * G, 0, 0, 0, 1, 1));
		// typical event: proton, second electron ignored, draw zero
		add_row(beat(1, 11, G, G / 2, -4 * G, 5 * G, 0, 0, 0, 0));
		add_row(beat(1, 2212, -G / 2, G / 4, 2 * G, 3 * G, 0, 0, 0, 0));
		add_row(beat(1, 11, 3 * G, 0, 0, 3 * G, 0, 0, 0, 0));
		add_row(beat(1, 2212, G, G, G, G, 0, 0, 0, 0));
		add_row(beat(1, 111, 0, 0, 0, 0, 10 * G, 0, 0, 1));
		// same electron, no proton, largest draw
		add_row(beat(1, 11, G, G / 2, -4 * G, 5 * G, 10 * G, 0, 20'hFFFFF, 1));
		// field extremes
		add_row(beat(8'hFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 20'hFFFFF, 0));
		add_row(beat(1, 11, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 0, 20'hFFFFF, 1));
		add_row(beat(0, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
		add_row(beat(1, 11, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 0, 0, 1));
		// backward electron, valid kinematics with a proton
		add_row(beat(1, 2212, 0, 0, 0, 983850, 0, 0, 0, 0));
		add_row(beat(1, 11, G / 4, 0, -6 * G, 6 * G, 18 * G, 0, 20'h80000, 1));

		write_wmax(31'd1048576);
		foreach (dir_tab[i]) drive_beat(dir_tab[i]);

		write_wmax(31'd1);
		random_phase(240);
		write_wmax(31'h7FFFFFFF);
		random_phase(240);
		write_wmax(31'd0);
		quiet = 1'b1;
		random_phase(240);
		quiet = 1'b0;
		write_wmax(31'($urandom_range(1 << 16, 1 << 22)));
		random_phase(240);
		write_wmax(31'($urandom));
		random_phase(240);
		write_wmax(31'd1048576);
		random_phase(240);

		in_valid <= 1'b0;
		while (events_pending.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
